// File: src/assert_macros.svh
// Assertion macros shared by the ray box slab test RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/rbst_pkg.sv
// Package for the ray box slab test: number format, register indexes and
// the scaled, saturating distance function. Depends on nothing.
package rbst_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = DIFF_WIDTH + COORD_WIDTH;
   localparam int NUM_STAGES  = 5;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [COORD_WIDTH-1:0] INV_DIR_RESET =
      (FRAC_BITS < COORD_WIDTH - 1) ? COORD_WIDTH'(64'd1 << FRAC_BITS) : COORD_MAX;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X  = 3'd0,
      REG_ORIGIN_Y  = 3'd1,
      REG_ORIGIN_Z  = 3'd2,
      REG_INV_DIR_X = 3'd3,
      REG_INV_DIR_Y = 3'd4,
      REG_INV_DIR_Z = 3'd5,
      REG_T_LOWER   = 3'd6,
      REG_T_UPPER   = 3'd7
   } rbst_reg_type;

   // Load enables of the three stages inside one axis unit.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } rbst_adv_type;

   // Floor shift by the fraction bits, then clamp to the coordinate range.
   function automatic coord_type scale_sat(prod_type p);
      prod_type                       shifted;
      logic [PROD_WIDTH-COORD_WIDTH:0] upper;
      shifted = p >>> FRAC_BITS;
      upper   = shifted[PROD_WIDTH-1:COORD_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         return shifted[COORD_WIDTH-1:0];
      end
      return shifted[PROD_WIDTH-1] ? COORD_MIN : COORD_MAX;
   endfunction

endpackage

// File: src/rbst_slab_axis.sv
// One axis of the slab test: plane selection, difference, product and
// saturated distances over three stages. Depends on rbst_pkg.
module rbst_slab_axis
   import rbst_pkg::*;
(
   input  logic         clock,
   input  rbst_adv_type adv,
   input  coord_type    box_lo,
   input  coord_type    box_hi,
   input  coord_type    origin,
   input  coord_type    inv_dir,
   output coord_type    t_near,
   output coord_type    t_far
);

   diff_type  diff_near_ff, diff_near_in, diff_far_ff, diff_far_in;
   prod_type  prod_near_ff, prod_near_in, prod_far_ff, prod_far_in;
   coord_type t_near_ff, t_near_in, t_far_ff, t_far_in;
   coord_type near_p, far_p;

   always_comb begin
      near_p       = inv_dir[COORD_WIDTH-1] ? box_hi : box_lo;
      far_p        = inv_dir[COORD_WIDTH-1] ? box_lo : box_hi;
      diff_near_in = DIFF_WIDTH'(near_p) - DIFF_WIDTH'(origin);
      diff_far_in  = DIFF_WIDTH'(far_p) - DIFF_WIDTH'(origin);
      prod_near_in = PROD_WIDTH'(diff_near_ff) * PROD_WIDTH'(inv_dir);
      prod_far_in  = PROD_WIDTH'(diff_far_ff) * PROD_WIDTH'(inv_dir);
      t_near_in    = scale_sat(prod_near_ff);
      t_far_in     = scale_sat(prod_far_ff);
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         diff_near_ff <= diff_near_in;
         diff_far_ff  <= diff_far_in;
      end
      if (adv.s2) begin
         prod_near_ff <= prod_near_in;
         prod_far_ff  <= prod_far_in;
      end
      if (adv.s3) begin
         t_near_ff <= t_near_in;
         t_far_ff  <= t_far_in;
      end
   end

   assign t_near = t_near_ff;
   assign t_far  = t_far_ff;

endmodule

// File: src/ray_box_slab_test_core.sv
// Top level of the ray box slab test: ray registers, pipeline control and
// the interval narrowing stages. Depends on rbst_pkg and rbst_slab_axis.
//
//   channel   direction   handshake           payload
//   req       in          req_valid/stall     req_box_min_*, req_box_max_*
//   rsp       out         rsp_valid/stall     rsp_hit
//   csr       in          csr_wr_en           csr_index, csr_wr_data
//
// One box beat is taken every cycle while req_stall is low; its hit beat passes
// through the difference, multiply, scale, narrow and final stages in turn.
// Each stage holds its own valid bit, so a stalled result fills bubbles first
// and req_stall rises only when all five stages are occupied.
// Synchronous reset clears the valid bits and loads the ray registers.
`include "assert_macros.svh"

module ray_box_slab_test_core
   import rbst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  coord_type              req_box_min_x,
   input  coord_type              req_box_min_y,
   input  coord_type              req_box_min_z,
   input  coord_type              req_box_max_x,
   input  coord_type              req_box_max_y,
   input  coord_type              req_box_max_z,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_index,
   input  logic [COORD_WIDTH-1:0] csr_wr_data
);

   coord_type origin_x_ff, origin_y_ff, origin_z_ff;
   coord_type inv_dir_x_ff, inv_dir_y_ff, inv_dir_z_ff;
   coord_type t_lower_ff, t_upper_ff;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] load;
   rbst_adv_type          adv;

   coord_type tn_x, tf_x, tn_y, tf_y, tn_z, tf_z;
   coord_type tmin_ff, tmin_in, tmax_ff, tmax_in, tn_z_ff, tf_z_ff;
   logic      ok_ff, ok_in;
   logic      hit_ff, hit_in;
   coord_type tmin_fin, tmax_fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         origin_z_ff  <= '0;
         inv_dir_x_ff <= INV_DIR_RESET;
         inv_dir_y_ff <= INV_DIR_RESET;
         inv_dir_z_ff <= INV_DIR_RESET;
         t_lower_ff   <= '0;
         t_upper_ff   <= COORD_MAX;
      end else if (csr_wr_en) begin
         case (rbst_reg_type'(csr_index))
            REG_ORIGIN_X:  origin_x_ff  <= csr_wr_data;
            REG_ORIGIN_Y:  origin_y_ff  <= csr_wr_data;
            REG_ORIGIN_Z:  origin_z_ff  <= csr_wr_data;
            REG_INV_DIR_X: inv_dir_x_ff <= csr_wr_data;
            REG_INV_DIR_Y: inv_dir_y_ff <= csr_wr_data;
            REG_INV_DIR_Z: inv_dir_z_ff <= csr_wr_data;
            REG_T_LOWER:   t_lower_ff   <= csr_wr_data;
            REG_T_UPPER:   t_upper_ff   <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      if (load[0]) begin
         valid_in[0] = req_valid;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (load[i]) begin
            valid_in[i] = valid_ff[i-1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
      adv.s1 = load[0];
      adv.s2 = load[1];
      adv.s3 = load[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   rbst_slab_axis u_axis_x (
      .clock   (clock),
      .adv     (adv),
      .box_lo  (req_box_min_x),
      .box_hi  (req_box_max_x),
      .origin  (origin_x_ff),
      .inv_dir (inv_dir_x_ff),
      .t_near  (tn_x),
      .t_far   (tf_x)
   );

   rbst_slab_axis u_axis_y (
      .clock   (clock),
      .adv     (adv),
      .box_lo  (req_box_min_y),
      .box_hi  (req_box_max_y),
      .origin  (origin_y_ff),
      .inv_dir (inv_dir_y_ff),
      .t_near  (tn_y),
      .t_far   (tf_y)
   );

   rbst_slab_axis u_axis_z (
      .clock   (clock),
      .adv     (adv),
      .box_lo  (req_box_min_z),
      .box_hi  (req_box_max_z),
      .origin  (origin_z_ff),
      .inv_dir (inv_dir_z_ff),
      .t_near  (tn_z),
      .t_far   (tf_z)
   );

   always_comb begin
      ok_in    = !((tn_x > tf_y) || (tn_y > tf_x));
      tmin_in  = (tn_y > tn_x) ? tn_y : tn_x;
      tmax_in  = (tf_y < tf_x) ? tf_y : tf_x;
      tmin_fin = (tn_z_ff > tmin_ff) ? tn_z_ff : tmin_ff;
      tmax_fin = (tf_z_ff < tmax_ff) ? tf_z_ff : tmax_ff;
      hit_in   = ok_ff && !((tmin_ff > tf_z_ff) || (tn_z_ff > tmax_ff))
                 && (tmax_fin > t_lower_ff) && (tmin_fin < t_upper_ff);
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         ok_ff   <= ok_in;
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
         tn_z_ff <= tn_z;
         tf_z_ff <= tf_z;
      end
      if (load[4]) begin
         hit_ff <= hit_in;
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_hit   = hit_ff;

   `ASSERT_CLK(a_stall_only_when_full, clock, reset, req_stall |-> (&valid_ff), "input stalled with a free stage")
   `ASSERT_CLK(a_held_stage_keeps_beat, clock, reset, (valid_ff[3] && !load[4]) |=> valid_ff[3], "held beat lost in narrow stage")
   `ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule
